// ----- sv/fdms_pkg.sv -----
// ============================================================================
// Frame difference motion score: shared package
// Widths, register indexes, reset values and divider control structs.
// ============================================================================
package fdms_pkg;

   // Sample store geometry.
   localparam int MAX_SAMPLES = 8192;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);

   // Field widths.
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int SCORE_W    = 16;
   localparam int STRIDE_W   = 11;
   localparam int PHASE_W    = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // Stride limits and register reset values.
   localparam logic [STRIDE_W-1:0] STRIDE_MIN     = STRIDE_W'(1);
   localparam logic [STRIDE_W-1:0] STRIDE_MAX     = STRIDE_W'(1024);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET   = STRIDE_W'(100);
   localparam logic [BYTE_W-1:0]   THRESH_RESET   = BYTE_W'(30);
   localparam logic [SCORE_W-1:0]  SCORE_SAT      = {SCORE_W{1'b1}};
   localparam logic [SCORE_W-1:0]  SCORE_ZERO     = '0;
   localparam logic [COUNT_W-1:0]  SAMPLE_LIMIT   = COUNT_W'(MAX_SAMPLES);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIFF_THRESHOLD = 1'b0,
      REG_SAMPLE_STRIDE  = 1'b1
   } csr_index_type;

   // Divider start request: quotient of (num << 16) / den with num < den.
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] num;
      logic [COUNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SCORE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/fdms_if.sv -----
// ============================================================================
// Frame difference motion score: channel interfaces
// Byte request channel and per-frame result channel, valid/ready handshake.
// ============================================================================
interface fdms_req_if;
   logic                         valid;
   logic                         ready;
   logic [fdms_pkg::BYTE_W-1:0]  pixel_byte;
   logic                         frame_end;

   modport source (output valid, output pixel_byte, output frame_end, input ready);
   modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

interface fdms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fdms_pkg::SCORE_W-1:0]  frac_score;
   logic [fdms_pkg::COUNT_W-1:0]  changed_samples;
   logic [fdms_pkg::COUNT_W-1:0]  compared_samples;
   logic                          first_frame;
   logic                          samples_truncated;

   modport source (output valid, output frac_score, output changed_samples,
                   output compared_samples, output first_frame,
                   output samples_truncated, input ready);
   modport sink   (input valid, input frac_score, input changed_samples,
                   input compared_samples, input first_frame,
                   input samples_truncated, output ready);
endinterface

// ----- sv/frame_difference_motion_score_unit.sv -----
// ============================================================================
// Frame difference motion score unit
// Compares sampled bytes of each frame against the previous frame and reports
// the changed fraction as an unsigned Q0.16 score once per frame.
// ============================================================================
//
//   Channel   Direction  Beat contents
//   --------  ---------  ------------------------------------------------------
//   req_chan  in         pixel_byte, frame_end (last byte of the frame)
//   rsp_chan  out        frac_score, changed_samples, compared_samples,
//                        first_frame, samples_truncated (one beat per frame)
//   csr_*     in         write enable, register index, write data
//
// Bytes inside a frame are taken one per cycle; the sample store is read and
// written in the same cycle and the comparison lands in the cycle after.
// After the last byte of a frame, req_chan.ready stays low through the settle
// state, the divider (sixteen quotient bits, then the hand-over of the
// quotient) and the load of the result register; that load waits while an
// earlier result is still held under a rsp_chan stall.
// Reset is synchronous and clears control state only; the sample store is not
// cleared, and an entry is compared only after the previous frame wrote it.
//
module frame_difference_motion_score_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   fdms_req_if.sink                             req_chan,
   fdms_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [fdms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fdms_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SETTLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [fdms_pkg::BYTE_W-1:0]   threshold_ff;
   logic [fdms_pkg::STRIDE_W-1:0] stride_ff;
   logic [fdms_pkg::STRIDE_W-1:0] stride_eff;

   // Frame tracking state.
   logic                          have_prev_ff;
   logic [fdms_pkg::COUNT_W-1:0]  prev_total_ff;
   logic [fdms_pkg::PHASE_W-1:0]  phase_ff;
   logic [fdms_pkg::PHASE_W-1:0]  phase_in;
   logic [fdms_pkg::STRIDE_W-1:0] phase_inc;
   logic [fdms_pkg::COUNT_W-1:0]  sample_index_ff;
   logic [fdms_pkg::COUNT_W-1:0]  sample_index_in;
   logic                          overflow_ff;
   logic [fdms_pkg::COUNT_W-1:0]  changed_ff;
   logic [fdms_pkg::COUNT_W-1:0]  changed_in;
   logic [fdms_pkg::COUNT_W-1:0]  compared_ff;
   logic [fdms_pkg::COUNT_W-1:0]  compared_in;

   // Sample store and compare stage.
   logic [fdms_pkg::BYTE_W-1:0]   sample_mem [fdms_pkg::MAX_SAMPLES];
   logic [fdms_pkg::BYTE_W-1:0]   mem_rd_ff;
   logic [fdms_pkg::BYTE_W-1:0]   byte_ff;
   logic                          cmp_valid_ff;
   logic [fdms_pkg::BYTE_W-1:0]   abs_diff;
   logic                          is_changed;

   // Handshake and sampling decisions.
   logic                          accept;
   logic                          at_sample;
   logic                          index_below;
   logic                          take_sample;
   logic                          overflow_hit;
   logic                          compare_hit;

   // Frame closing and result path.
   state_type                     state_ff;
   logic                          first_snap_ff;
   logic                          trunc_snap_ff;
   logic [fdms_pkg::COUNT_W-1:0]  chg_snap_ff;
   logic [fdms_pkg::COUNT_W-1:0]  cmp_snap_ff;
   logic [fdms_pkg::SCORE_W-1:0]  score_ff;
   logic                          need_div;
   logic                          rsp_load;
   logic                          rsp_valid_ff;
   logic [fdms_pkg::SCORE_W-1:0]  rsp_score_ff;
   logic [fdms_pkg::COUNT_W-1:0]  rsp_changed_ff;
   logic [fdms_pkg::COUNT_W-1:0]  rsp_compared_ff;
   logic                          rsp_first_ff;
   logic                          rsp_trunc_ff;

   fdms_pkg::div_req_type         div_req;
   fdms_pkg::div_rsp_type         div_rsp;

   // ------------------------------------------------------------------------
   // Configuration writes. The stride in use is clamped to 1..1024.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= fdms_pkg::THRESH_RESET;
         stride_ff    <= fdms_pkg::STRIDE_RESET;
      end else if (csr_write_enable) begin
         unique case (fdms_pkg::csr_index_type'(csr_index))
            fdms_pkg::REG_DIFF_THRESHOLD: begin
               threshold_ff <= csr_write_data[fdms_pkg::BYTE_W-1:0];
            end
            fdms_pkg::REG_SAMPLE_STRIDE: begin
               stride_ff <= csr_write_data[fdms_pkg::STRIDE_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      if (stride_ff < fdms_pkg::STRIDE_MIN) begin
         stride_eff = fdms_pkg::STRIDE_MIN;
      end else if (stride_ff > fdms_pkg::STRIDE_MAX) begin
         stride_eff = fdms_pkg::STRIDE_MAX;
      end else begin
         stride_eff = stride_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Byte intake. A byte at phase zero is a sample; while the store has room
   // it is written at its index, and the old entry is read in the same cycle
   // (read before write) for the compare stage.
   // ------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_RUN);
   assign accept         = req_chan.valid && req_chan.ready;
   assign at_sample      = accept && (phase_ff == '0);
   assign index_below    = sample_index_ff < fdms_pkg::SAMPLE_LIMIT;
   assign take_sample    = at_sample && index_below;
   assign overflow_hit   = at_sample && !index_below;
   assign compare_hit    = take_sample && have_prev_ff && (sample_index_ff < prev_total_ff);

   // The phase wraps as soon as it reaches the stride, even one changed
   // in the middle of a frame.
   assign phase_inc       = {1'b0, phase_ff} + fdms_pkg::STRIDE_W'(1);
   assign phase_in        = (phase_inc >= stride_eff) ? '0
                                                      : phase_inc[fdms_pkg::PHASE_W-1:0];
   assign sample_index_in = sample_index_ff + fdms_pkg::COUNT_W'(take_sample);

   always_ff @(posedge clock) begin
      if (take_sample) begin
         mem_rd_ff <= sample_mem[sample_index_ff[fdms_pkg::ADDR_W-1:0]];
         sample_mem[sample_index_ff[fdms_pkg::ADDR_W-1:0]] <= req_chan.pixel_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff    <= 1'b0;
         prev_total_ff   <= '0;
         phase_ff        <= '0;
         sample_index_ff <= '0;
         overflow_ff     <= 1'b0;
         cmp_valid_ff    <= 1'b0;
      end else begin
         cmp_valid_ff <= compare_hit;
         if (accept) begin
            if (req_chan.frame_end) begin
               have_prev_ff    <= 1'b1;
               prev_total_ff   <= sample_index_in;
               phase_ff        <= '0;
               sample_index_ff <= '0;
               overflow_ff     <= 1'b0;
            end else begin
               phase_ff        <= phase_in;
               sample_index_ff <= sample_index_in;
               overflow_ff     <= overflow_ff || overflow_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.pixel_byte;
      end
   end

   // ------------------------------------------------------------------------
   // Compare stage: the tallies move in the cycle after the store read.
   // ------------------------------------------------------------------------
   always_comb begin
      abs_diff    = (byte_ff > mem_rd_ff) ? byte_ff - mem_rd_ff : mem_rd_ff - byte_ff;
      is_changed  = abs_diff > threshold_ff;
      changed_in  = changed_ff + fdms_pkg::COUNT_W'(cmp_valid_ff && is_changed);
      compared_in = compared_ff + fdms_pkg::COUNT_W'(cmp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         changed_ff  <= '0;
         compared_ff <= '0;
      end else if (state_ff == ST_SETTLE) begin
         changed_ff  <= '0;
         compared_ff <= '0;
      end else begin
         changed_ff  <= changed_in;
         compared_ff <= compared_in;
      end
   end

   // ------------------------------------------------------------------------
   // Frame close. The settle cycle lets the last compare land, then the
   // totals are captured. The divider runs only for a fraction below one;
   // the first frame and an empty comparison give zero, a frame with every
   // compared sample changed gives the saturated score.
   // ------------------------------------------------------------------------
   assign need_div = !first_snap_ff && (compared_in != '0) && (changed_in < compared_in);

   assign div_req.start = (state_ff == ST_SETTLE) && need_div;
   assign div_req.num   = changed_in;
   assign div_req.den   = compared_in;

   fdms_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The result register takes a new beat when it is empty or is being
   // drained in the same cycle.
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (accept && req_chan.frame_end) begin
                  first_snap_ff <= !have_prev_ff;
                  trunc_snap_ff <= overflow_ff || overflow_hit;
                  state_ff      <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               chg_snap_ff <= changed_in;
               cmp_snap_ff <= compared_in;
               if (first_snap_ff || (compared_in == '0)) begin
                  score_ff <= fdms_pkg::SCORE_ZERO;
               end else begin
                  score_ff <= fdms_pkg::SCORE_SAT;
               end
               state_ff <= need_div ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE: begin
               if (div_rsp.done) begin
                  score_ff <= div_rsp.quotient;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_score_ff    <= score_ff;
                  rsp_changed_ff  <= chg_snap_ff;
                  rsp_compared_ff <= cmp_snap_ff;
                  rsp_first_ff    <= first_snap_ff;
                  rsp_trunc_ff    <= trunc_snap_ff;
                  state_ff        <= ST_RUN;
               end
            end
         endcase
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.frac_score        = rsp_score_ff;
   assign rsp_chan.changed_samples   = rsp_changed_ff;
   assign rsp_chan.compared_samples  = rsp_compared_ff;
   assign rsp_chan.first_frame       = rsp_first_ff;
   assign rsp_chan.samples_truncated = rsp_trunc_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_changed_le_compared: assert property (@(posedge clock) disable iff (reset)
      changed_ff <= compared_ff)
      else $error("changed tally exceeds compared tally");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= fdms_pkg::SAMPLE_LIMIT)
      else $error("sample index past store capacity");

   a_cmp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> $past(accept))
      else $error("compare stage active without an accepted byte");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

endmodule

// ----- sv/fdms_div.sv -----
// ============================================================================
// Frame difference motion score: fraction divider
// Restoring divider, one quotient bit per cycle, for (num << 16) / den.
// ============================================================================
module fdms_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fdms_pkg::div_req_type req,
   output fdms_pkg::div_rsp_type rsp
);

   localparam int STEP_W = $clog2(fdms_pkg::SCORE_W + 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [STEP_W-1:0]            count_ff;
   logic [fdms_pkg::COUNT_W-1:0] rem_ff;
   logic [fdms_pkg::COUNT_W-1:0] den_ff;
   logic [fdms_pkg::SCORE_W-1:0] quo_ff;

   logic [fdms_pkg::COUNT_W:0]   shifted;
   logic                         fits;
   logic [fdms_pkg::COUNT_W-1:0] rem_in;

   // The remainder stays below the divisor, so one trial subtraction per bit.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? fdms_pkg::COUNT_W'(shifted - {1'b0, den_ff})
                     : shifted[fdms_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= STEP_W'(fdms_pkg::SCORE_W);
            rem_ff   <= req.num;
            den_ff   <= req.den;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            quo_ff   <= {quo_ff[fdms_pkg::SCORE_W-2:0], fits};
            count_ff <= count_ff - STEP_W'(1);
            if (count_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
